@@ rtl/hue_to_rgb_converter_top_assert.svh @@
// Assertion macros for the hue-to-RGB converter.
// Expects clk and rst to be visible where the macros are used.
`ifndef HUE_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`define HUE_TO_RGB_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define H2R_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define H2R_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/h2r_pkg.sv @@
// Shared constants and types for the hue-to-RGB converter.
// No dependencies.
package h2r_pkg;

  localparam int COLOR_W = 24;
  localparam int PCT_W   = 15;
  localparam int CH_W    = 8;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // Register indexes
  localparam logic REG_SATURATION = 1'b0;
  localparam logic REG_BRIGHTNESS = 1'b1;

  localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;

  // Hue over 60 degrees, Q3.16
  localparam int HEX_W    = 19;
  localparam int FRAC_W   = 16;
  localparam logic [HEX_W-1:0] HEX_MAX = 19'd392123;
  // Smallest positive color whose hue lands past the clamp
  localparam logic [COLOR_W-1:0] COLOR_CLAMP = 24'd25529;

  // floor(x / 25) = (x * DIV25_MUL) >> DIV25_SHIFT for x < 2^24
  localparam int PROD1_W = 49;
  localparam logic [24:0] DIV25_MUL = 25'd21474837;
  localparam int DIV25_SHIFT = 29;

  // 25600 * 65536
  localparam int T_W = 31;
  localparam logic [T_W-1:0] SCALE = 31'd1677721600;

  localparam int SG_W = 32;
  localparam int W_W  = 46;
  localparam int N_W  = 54;
  // Half of 625 * 2^36 for round-half-up
  localparam logic [N_W-1:0] ROUND_HALF = 54'd21474836480000;
  localparam int N_SHIFT = 36;
  localparam int Y_W = 18;

  // floor(y / 625) = (y * DIV625_MUL) >> DIV625_SHIFT for y < 2^18
  localparam logic [18:0] DIV625_MUL = 19'd429497;
  localparam int DIV625_SHIFT = 28;
  localparam int PROD5_W = 37;

  // Channel lanes: v, v(1-s), v(1-s*f), v(1-s*(1-f))
  localparam int NUM_LANES = 4;
  localparam int LANE_V = 0;
  localparam int LANE_X = 1;
  localparam int LANE_Y = 2;
  localparam int LANE_Z = 3;

  typedef enum logic [1:0] {
    HEX_ZERO,
    HEX_CALC,
    HEX_CLAMP
  } hex_mode_t;

  localparam logic [2:0] SECTOR_0 = 3'd0;
  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;
  localparam logic [2:0] SECTOR_5 = 3'd5;

endpackage

@@ rtl/hue_to_rgb_converter_top.sv @@
// Hue-to-RGB converter: five-stage pipeline plus APB register port.
// Depends on h2r_pkg and hue_to_rgb_converter_top_assert.svh.
//
//   channel  | signals                                 | direction
//   ---------+-----------------------------------------+----------
//   input    | in_valid, in_ready, color_value         | in
//   result   | out_valid, out_ready, red, green, blue  | out
//   config   | psel, penable, pwrite, paddr, pwdata,   | in/out
//            | prdata, pready                          |
//
// One transaction per cycle, while the result is not stalled, through five
// register ranks (divide by 25, s*f, v*t, 255*w plus half, divide by 625 and
// routing). Reset clears all stage valid bits and loads both registers with
// 100 percent. A stalled result freezes the whole pipeline; in_ready drops
// only while out_valid is high and out_ready is low.
`include "hue_to_rgb_converter_top_assert.svh"

module hue_to_rgb_converter_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [h2r_pkg::COLOR_W-1:0]   color_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [h2r_pkg::CH_W-1:0]      red,
  output logic [h2r_pkg::CH_W-1:0]      green,
  output logic [h2r_pkg::CH_W-1:0]      blue,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [h2r_pkg::ADDR_W-1:0]    paddr,
  input  logic [h2r_pkg::DATA_W-1:0]    pwdata,
  output logic [h2r_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import h2r_pkg::*;

  logic [PCT_W-1:0] saturation_pct;
  logic [PCT_W-1:0] brightness_pct;
  logic [PCT_W-1:0] sat;
  logic [PCT_W-1:0] bri;
  logic             cfg_write;
  logic             advance;

  // Stage registers
  logic                      v1, v2, v3, v4;
  hex_mode_t                 mode1;
  logic [PROD1_W-1:0]        prod1;
  logic [2:0]                sector2, sector3, sector4;
  logic [SG_W-1:0]           sg_y, sg_z;
  logic [NUM_LANES-1:0][W_W-1:0] wsum;
  logic [NUM_LANES-1:0][Y_W-1:0] yval;

  // Combinational
  hex_mode_t                 mode_next;
  logic [COLOR_W-1:0]        xscaled;
  logic [PROD1_W-1:0]        prod1_next;
  logic [HEX_W-1:0]          hex;
  logic [FRAC_W:0]           g_f, g_c;
  logic [NUM_LANES-1:0][T_W-1:0]   tval;
  logic [NUM_LANES-1:0][N_W-1:0]   nval;
  logic [NUM_LANES-1:0][PROD5_W-1:0] prod5;
  logic [NUM_LANES-1:0][CH_W-1:0]  q;
  logic [CH_W-1:0]           red_next, green_next, blue_next;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation_pct <= PCT_FULL;
      brightness_pct <= PCT_FULL;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_SATURATION: saturation_pct <= pwdata[PCT_W-1:0];
        REG_BRIGHTNESS: brightness_pct <= pwdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SATURATION: prdata = DATA_W'(saturation_pct);
      REG_BRIGHTNESS: prdata = DATA_W'(brightness_pct);
      default:        prdata = '0;
    endcase
  end

  assign sat = (saturation_pct > PCT_FULL) ? PCT_FULL : saturation_pct;
  assign bri = (brightness_pct > PCT_FULL) ? PCT_FULL : brightness_pct;

  // Whole pipeline holds while the result is stalled
  assign advance  = !(out_valid && !out_ready);
  assign in_ready = advance;

  // Stage 1: clamp decision and color * 384 / 25 by reciprocal
  always_comb begin
    if (color_value[COLOR_W-1] || color_value == '0) begin
      mode_next = HEX_ZERO;
    end else if (color_value >= COLOR_CLAMP) begin
      mode_next = HEX_CLAMP;
    end else begin
      mode_next = HEX_CALC;
    end
    xscaled    = COLOR_W'({color_value[14:0], 8'b0}) + COLOR_W'({color_value[14:0], 7'b0});
    prod1_next = PROD1_W'(xscaled) * PROD1_W'(DIV25_MUL);
  end

  // Stage 2: sector and fraction, then s*f and s*(1-f)
  always_comb begin
    case (mode1)
      HEX_ZERO:  hex = '0;
      HEX_CLAMP: hex = HEX_MAX;
      HEX_CALC:  hex = prod1[DIV25_SHIFT +: HEX_W];
      default:   hex = '0;
    endcase
    g_f = {1'b0, hex[FRAC_W-1:0]};
    g_c = {1'b1, {FRAC_W{1'b0}}} - g_f;
  end

  // Stage 3: t = scale - s*g per lane, then v*t
  always_comb begin
    tval[LANE_V] = SCALE;
    tval[LANE_X] = SCALE - T_W'({sat, {FRAC_W{1'b0}}});
    tval[LANE_Y] = SCALE - T_W'(sg_y);
    tval[LANE_Z] = SCALE - T_W'(sg_z);
  end

  // Stage 4: 255*w plus half, drop 2^36
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      nval[i] = (N_W'(wsum[i]) << 8) - N_W'(wsum[i]) + ROUND_HALF;
    end
  end

  // Stage 5: divide by 625 and route by sector
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      prod5[i] = PROD5_W'(yval[i]) * PROD5_W'(DIV625_MUL);
      q[i]     = prod5[i][DIV625_SHIFT +: CH_W];
    end
    case (sector4)
      SECTOR_0: begin
        red_next = q[LANE_V]; green_next = q[LANE_Z]; blue_next = q[LANE_X];
      end
      SECTOR_1: begin
        red_next = q[LANE_Y]; green_next = q[LANE_V]; blue_next = q[LANE_X];
      end
      SECTOR_2: begin
        red_next = q[LANE_X]; green_next = q[LANE_V]; blue_next = q[LANE_Z];
      end
      SECTOR_3: begin
        red_next = q[LANE_X]; green_next = q[LANE_Y]; blue_next = q[LANE_V];
      end
      SECTOR_4: begin
        red_next = q[LANE_Z]; green_next = q[LANE_X]; blue_next = q[LANE_V];
      end
      default: begin
        red_next = q[LANE_V]; green_next = q[LANE_X]; blue_next = q[LANE_Y];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode1   <= mode_next;
      prod1   <= prod1_next;
      sector2 <= hex[HEX_W-1:FRAC_W];
      sg_y    <= SG_W'(sat) * SG_W'(g_f);
      sg_z    <= SG_W'(sat) * SG_W'(g_c);
      sector3 <= sector2;
      for (int i = 0; i < NUM_LANES; i++) begin
        wsum[i] <= W_W'(bri) * W_W'(tval[i]);
        yval[i] <= nval[i][N_SHIFT +: Y_W];
      end
      sector4 <= sector3;
      red     <= red_next;
      green   <= green_next;
      blue    <= blue_next;
    end
  end

  `H2R_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, v1,
    "accepted transaction did not enter stage one")
  `H2R_ASSERT_NOW(a_sector_range, v3, sector2 <= SECTOR_5 && sector3 <= SECTOR_5,
    "hue sector out of range")
  `H2R_ASSERT_NOW(a_round_range, v4,
    yval[LANE_V] <= 18'd159687 && yval[LANE_Y] <= 18'd159687 &&
    yval[LANE_Z] <= 18'd159687,
    "rounded channel exceeds 255.5 before divide")

endmodule

@@ sim/tb_top.sv @@
// Testbench for hue_to_rgb_converter_top: hue corners at reset settings, then random colors
// under extreme and random saturation/brightness, checked against an in-bench predictor.
// Depends on h2r_pkg and the hue_to_rgb_converter_top RTL.
module tb_top;
  import h2r_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    rgb_t               rgb;
  } rgb_expect_t;

  localparam longint unsigned PCT_MAX   = 25600;
  localparam longint unsigned FRAC_FULL = 65536;
  // floor(359 / 60 * 2^16): hue over 60 degrees never goes past this
  localparam longint unsigned HUE_CAP   = 392123;
  localparam int              PHASE_LEN = 140;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [COLOR_W-1:0] color_value = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [CH_W-1:0]    red;
  logic [CH_W-1:0]    green;
  logic [CH_W-1:0]    blue;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [ADDR_W-1:0]  paddr       = '0;
  logic [DATA_W-1:0]  pwdata      = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // Shadow copies of the two registers, raw 15-bit values
  logic [PCT_W-1:0] sat_reg = 15'd25600;
  logic [PCT_W-1:0] bri_reg = 15'd25600;

  rgb_expect_t rgb_expected_q[$];
  int          mismatches = 0;
  bit          idle_on    = 1'b1;
  int          stall_left = 0;

  hue_to_rgb_converter_top i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Exact rational channel value, scaled by 255 and rounded half up
  function automatic logic [CH_W-1:0] channel_level(longint unsigned s, longint unsigned v,
                                                    longint unsigned g);
    longint unsigned scale, num, den;
    scale = PCT_MAX * FRAC_FULL;
    num   = v * (scale - s * g) * 255;
    den   = PCT_MAX * scale;
    return CH_W'((num * 2 + den) / (den * 2));
  endfunction

  function automatic rgb_t predict_rgb(logic [COLOR_W-1:0] color);
    longint unsigned hex, frac, s, v;
    logic [2:0]      sector;
    logic [CH_W-1:0] lv, lx, ly, lz;
    rgb_t            p;
    // Clamp negative and zero colors to hue 0, large ones to 359 degrees
    if (color[COLOR_W-1] || color == '0) begin
      hex = 0;
    end else begin
      hex = color;
      hex = hex * 384 / 25;
      if (hex > HUE_CAP) hex = HUE_CAP;
    end
    sector = 3'(hex >> 16);
    frac   = hex & (FRAC_FULL - 1);
    s  = (sat_reg > PCT_MAX) ? PCT_MAX : sat_reg;
    v  = (bri_reg > PCT_MAX) ? PCT_MAX : bri_reg;
    lv = channel_level(s, v, 0);
    lx = channel_level(s, v, FRAC_FULL);
    ly = channel_level(s, v, frac);
    lz = channel_level(s, v, FRAC_FULL - frac);
    case (sector)
      SECTOR_0: p = '{lv, lz, lx};
      SECTOR_1: p = '{ly, lv, lx};
      SECTOR_2: p = '{lx, lv, lz};
      SECTOR_3: p = '{lx, ly, lv};
      SECTOR_4: p = '{lz, lx, lv};
      default:  p = '{lv, lx, ly};
    endcase
    return p;
  endfunction

  function automatic logic [COLOR_W-1:0] rand_color();
    case ($urandom_range(0, 9))
      0:       return COLOR_W'($urandom);
      1:       return COLOR_W'(-$urandom_range(0, 400));
      2:       return COLOR_W'($urandom_range(25400, 26000));
      default: return COLOR_W'($urandom_range(1, 25600));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("tb: mismatch: %s", what);
  endtask

  task automatic send_color(input logic [COLOR_W-1:0] color);
    rgb_expect_t e;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    color_value <= color;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e.color = color;
    e.rgb   = predict_rgb(color);
    rgb_expected_q = {rgb_expected_q, e};
  endtask

  // Drop valid and hold until every expected transaction has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (rgb_expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_colors(input int count);
    repeat (count) send_color(rand_color());
    drain();
  endtask

  // APB setup and access phases; the caller closes the transfer
  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
  endtask

  task automatic set_register(input logic idx, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rd;
    apb_access(1'b1, {idx, 2'b00}, data, rd);
    if (idx == REG_SATURATION) sat_reg = data[PCT_W-1:0];
    else bri_reg = data[PCT_W-1:0];
    apb_access(1'b0, {idx, 2'b00}, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (rd !== DATA_W'(data[PCT_W-1:0]))
      report_mismatch($sformatf("register %0d read %0h, expected %0h", idx, rd,
                                data[PCT_W-1:0]));
  endtask

  task automatic set_levels(input logic [DATA_W-1:0] sat, input logic [DATA_W-1:0] bri);
    set_register(REG_SATURATION, sat);
    set_register(REG_BRIGHTNESS, bri);
  endtask

  task automatic test_hue_corners();
    logic [COLOR_W-1:0] corners[$];
    // zero, smallest step, negatives, field extremes, sector edges, hue clamp edge
    corners = '{24'd0, 24'd1, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'd4266, 24'd4267,
                24'd8533, 24'd8534, 24'd12800, 24'd17066, 24'd17067, 24'd21333,
                24'd21334, 24'd25528, 24'd25529, 24'd25600, 24'd12345};
    foreach (corners[i]) send_color(corners[i]);
    drain();
  endtask

  task automatic test_register_extremes();
    logic [DATA_W-1:0] sats[$], bris[$];
    // the last two saturations and the fifth brightness exceed 100 percent and must saturate
    sats = '{32'd0, 32'd0,     32'd25600, 32'd25600, 32'd32767, 32'd25601};
    bris = '{32'd0, 32'd25600, 32'd0,     32'd25600, 32'd32767, 32'd1};
    foreach (sats[i]) begin
      set_levels(sats[i], bris[i]);
      run_colors(100);
    end
  endtask

  function automatic logic [DATA_W-1:0] rand_level();
    if ($urandom_range(0, 1) == 0) return DATA_W'($urandom_range(0, 25600));
    return $urandom;
  endfunction

  task automatic test_random_registers();
    repeat (7) begin
      set_levels(rand_level(), rand_level());
      run_colors(PHASE_LEN);
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    set_levels(rand_level(), rand_level());
    run_colors(250);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rgb_expect_t e;
    if (!rst && out_valid && out_ready) begin
      if (rgb_expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d", red, green, blue));
      end else begin
        e = rgb_expected_q.pop_front();
        if (red !== e.rgb.red || green !== e.rgb.green || blue !== e.rgb.blue)
          report_mismatch($sformatf("color %0h: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                    e.color, e.rgb.red, e.rgb.green, e.rgb.blue,
                                    red, green, blue));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_hue_corners();
    test_register_extremes();
    test_random_registers();
    test_steady_stream();
    // allow for any stray output past the pipeline depth
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/h2r_pkg.sv
rtl/hue_to_rgb_converter_top.sv
sim/tb_top.sv
